/* design/nss_pkg.sv */
// Shared constants, types and helpers of the note string sequencer.
`timescale 1ns / 1ps

package nss_pkg;

    // Width of the running note duration.
    localparam int DUR_BITS = 16;

    localparam int QUARTER_W = 12;
    localparam int OCT_W     = 4;
    localparam int FREQ_W    = 15;
    localparam int OUT_W     = 16;
    localparam int TONE_W    = 10;
    localparam int IDX_W     = 3;

    localparam logic [QUARTER_W-1:0] QUARTER_RST = 12'd800;
    localparam logic [OCT_W-1:0]     OCT_RST     = 4'd4;

    // Configuration register indexes.
    localparam logic REG_QUARTER = 1'b0;

    // Characters with a meaning.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;

    // Event kinds.
    localparam logic EVT_TONE = 1'b0;
    localparam logic EVT_REST = 1'b1;

    // x / 3 by reciprocal for x below 2^(DUR_BITS+1).
    localparam int DIV3_SH = DUR_BITS + 3;
    localparam logic [DUR_BITS+1:0] DIV3_MUL =
        (DUR_BITS+2)'(((64'd1 << DIV3_SH) + 64'd2) / 64'd3);

    // x / 10 by reciprocal for x below 2^(DUR_BITS+4).
    localparam int DIV10_SH = DUR_BITS + 8;
    localparam logic [DUR_BITS+4:0] DIV10_MUL =
        (DUR_BITS+5)'(((64'd1 << DIV10_SH) + 64'd9) / 64'd10);

    localparam int SAT_W = (DUR_BITS > OUT_W) ? DUR_BITS : OUT_W;

    typedef logic [DUR_BITS-1:0] dur_t;

    // One queued event.
    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] tone_idx;
        logic [OCT_W-1:0] octave;
        dur_t             dur;
    } nss_evt_t;

    // Push side of the event queue.
    typedef struct packed {
        logic     valid;
        nss_evt_t evt;
    } nss_push_t;

    // Pop side of the event queue.
    typedef struct packed {
        logic     valid;
        nss_evt_t evt;
    } nss_head_t;

    function automatic logic [TONE_W-1:0] tone_base(input logic [IDX_W-1:0] idx);
        logic [TONE_W-1:0] f;
        unique case (idx)
            3'd0:    f = 10'd440;
            3'd1:    f = 10'd494;
            3'd2:    f = 10'd523;
            3'd3:    f = 10'd587;
            3'd4:    f = 10'd659;
            3'd5:    f = 10'd698;
            3'd6:    f = 10'd784;
            default: f = 10'd440;
        endcase
        return f;
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(input dur_t v);
        logic [SAT_W-1:0] w;
        w = SAT_W'(v);
        return (w > SAT_W'(17'd65535)) ? 16'hFFFF : w[OUT_W-1:0];
    endfunction

endpackage

/* design/nss_if.sv */
// Channel interfaces: character input and event output.
`timescale 1ns / 1ps

interface nss_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface nss_event_if;
    logic        valid;
    logic        ready;
    logic        event_kind;
    logic [14:0] freq_hz;
    logic [15:0] on_ms;
    logic [15:0] off_ms;

    modport source (output valid, output event_kind, output freq_hz, output on_ms,
                    output off_ms, input ready);
    modport sink   (input valid, input event_kind, input freq_hz, input on_ms,
                    input off_ms, output ready);
endinterface

/* design/nss_cfg.sv */
// APB register block holding the quarter note length.
`timescale 1ns / 1ps

module nss_cfg
    import nss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output logic [QUARTER_W-1:0] quarter_len
);

    logic [QUARTER_W-1:0] quarter_reg;
    logic [QUARTER_W-1:0] quarter_next;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_QUARTER);

    always_comb
    begin
        quarter_next = quarter_reg;
        if (wr_en)
        begin
            quarter_next = pwdata[QUARTER_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quarter_reg <= QUARTER_RST;
        end
        else
        begin
            quarter_reg <= quarter_next;
        end
    end

    assign prdata      = (paddr[2] == REG_QUARTER) ? {20'd0, quarter_reg} : 32'd0;
    assign quarter_len = quarter_reg;

endmodule

/* design/nss_front.sv */
// Front end: take characters, track octave, duration and meter skip, emit events.
`timescale 1ns / 1ps

module nss_front
    import nss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [QUARTER_W-1:0] quarter_len,
    input  logic                 push_ready,
    output nss_push_t            push,
    nss_char_if.sink             char_ch
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_DIGIT1 = 2'd1;
    localparam logic [1:0] PH_SLASH  = 2'd2;
    localparam logic [1:0] PH_DIGIT2 = 2'd3;

    typedef logic [DUR_BITS+1:0] wide_t;

    logic [OCT_W-1:0] oct_reg;
    logic [OCT_W-1:0] oct_next;
    dur_t             dur_reg;
    dur_t             dur_next;
    logic [1:0]       phase_reg;
    logic [1:0]       phase_next;

    logic             acc;
    logic [7:0]       c;
    logic             is_digit;
    logic             consumed;
    logic [1:0]       ph;

    logic [2*DUR_BITS+2:0] prod3;
    dur_t                  dur_trip;
    wide_t                 q_wide;
    dur_t                  dur_whole;
    dur_t                  dur_half;
    dur_t                  dur_quart;
    dur_t                  dur_eighth;
    dur_t                  dur_sixt;
    dur_t                  dur_dot;

    function automatic dur_t sat_dur(input wide_t v);
        return (v > wide_t'({DUR_BITS{1'b1}})) ? {DUR_BITS{1'b1}} : v[DUR_BITS-1:0];
    endfunction

    assign char_ch.ready = push_ready;
    assign acc           = char_ch.valid && push_ready;
    assign c             = char_ch.ch;
    assign is_digit      = (c >= CH_ZERO) && (c <= CH_NINE);

    // Duration candidates.
    assign q_wide     = wide_t'(quarter_len);
    assign dur_whole  = sat_dur(q_wide << 2);
    assign dur_half   = sat_dur(q_wide << 1);
    assign dur_quart  = sat_dur(q_wide);
    assign dur_eighth = sat_dur(q_wide >> 1);
    assign dur_sixt   = sat_dur(q_wide >> 2);
    assign dur_dot    = sat_dur((wide_t'(dur_reg) + (wide_t'(dur_reg) << 1)) >> 1);
    assign prod3      = (2*DUR_BITS+3)'({dur_reg, 1'b0}) * (2*DUR_BITS+3)'(DIV3_MUL);
    assign dur_trip   = prod3[DIV3_SH +: DUR_BITS];

    always_comb
    begin
        oct_next   = oct_reg;
        dur_next   = dur_reg;
        phase_next = phase_reg;
        push.valid = 1'b0;
        push.evt.kind     = EVT_TONE;
        push.evt.tone_idx = IDX_W'(c - CH_A);
        push.evt.octave   = oct_reg;
        push.evt.dur      = dur_reg;
        ph         = phase_reg;
        consumed   = 1'b0;

        if (acc)
        begin
            if (c == CH_NUL)
            begin
                oct_next   = OCT_RST;
                dur_next   = dur_quart;
                phase_next = PH_IDLE;
            end
            else
            begin
                // Meter mark skip: each step falls through on a mismatch.
                if (ph == PH_DIGIT1)
                begin
                    ph = PH_SLASH;
                    consumed = is_digit;
                end
                if (!consumed && ph == PH_SLASH)
                begin
                    ph = PH_DIGIT2;
                    consumed = (c == CH_SLASH);
                end
                if (!consumed && ph == PH_DIGIT2)
                begin
                    ph = PH_IDLE;
                    consumed = is_digit;
                end
                phase_next = ph;

                if (!consumed)
                begin
                    if (is_digit)
                    begin
                        oct_next = c[OCT_W-1:0];
                    end
                    else
                    begin
                        unique case (c)
                            CH_M: phase_next = PH_DIGIT1;
                            CH_W: dur_next = dur_whole;
                            CH_H: dur_next = dur_half;
                            CH_Q: dur_next = dur_quart;
                            CH_E: dur_next = dur_eighth;
                            CH_S: dur_next = dur_sixt;
                            CH_T: dur_next = dur_trip;
                            CH_DOT: dur_next = dur_dot;
                            CH_R:
                            begin
                                push.valid    = 1'b1;
                                push.evt.kind = EVT_REST;
                            end
                            default:
                            begin
                                if (c >= CH_A && c <= CH_G)
                                begin
                                    push.valid = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_reg   <= OCT_RST;
            dur_reg   <= DUR_BITS'(QUARTER_RST);
            phase_reg <= PH_IDLE;
        end
        else
        begin
            oct_reg   <= oct_next;
            dur_reg   <= dur_next;
            phase_reg <= phase_next;
        end
    end

endmodule

/* design/nss_queue.sv */
// Four-entry event queue between front and back end.
`timescale 1ns / 1ps

module nss_queue
    import nss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  nss_push_t push,
    output logic      push_ready,
    output nss_head_t head,
    input  logic      pop
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    nss_evt_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != (PTR_W+1)'(DEPTH));
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && head.valid;
    assign head.valid = (count_reg != '0);
    assign head.evt   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.evt;
        end
    end

endmodule

/* design/nss_back.sv */
// Back end: turn a queued event into frequency and on/off times, hold it for transfer.
`timescale 1ns / 1ps

module nss_back
    import nss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  nss_head_t  head,
    output logic       pop,
    nss_event_if.source event_ch
);

    localparam int SHW = TONE_W + 11;

    logic                  valid_reg;
    logic                  valid_next;
    logic                  kind_reg;
    logic [FREQ_W-1:0]     freq_reg;
    logic [OUT_W-1:0]      on_reg;
    logic [OUT_W-1:0]      off_reg;

    logic [DUR_BITS+3:0]   p9;
    logic [2*DUR_BITS+8:0] prod10;
    dur_t                  on_dur;
    dur_t                  off_dur;
    logic [SHW-1:0]        f_wide;
    logic [FREQ_W-1:0]     freq_calc;
    logic [OUT_W-1:0]      on_calc;
    logic [OUT_W-1:0]      off_calc;

    assign pop = head.valid && (!valid_reg || event_ch.ready);

    // on = floor(dur * 9 / 10), off = dur - on.
    assign p9      = (DUR_BITS+4)'(head.evt.dur) + ((DUR_BITS+4)'(head.evt.dur) << 3);
    assign prod10  = (2*DUR_BITS+9)'(p9) * (2*DUR_BITS+9)'(DIV10_MUL);
    assign on_dur  = prod10[DIV10_SH +: DUR_BITS];
    assign off_dur = head.evt.dur - on_dur;

    always_comb
    begin
        if (head.evt.octave >= OCT_RST)
        begin
            f_wide = SHW'(tone_base(head.evt.tone_idx)) << (head.evt.octave - OCT_RST);
        end
        else
        begin
            f_wide = SHW'(tone_base(head.evt.tone_idx)) >> (OCT_RST - head.evt.octave);
        end

        if (head.evt.kind == EVT_REST)
        begin
            freq_calc = '0;
            on_calc   = '0;
            off_calc  = sat_out(head.evt.dur);
        end
        else
        begin
            freq_calc = f_wide[FREQ_W-1:0];
            on_calc   = sat_out(on_dur);
            off_calc  = sat_out(off_dur);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (event_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= head.evt.kind;
            freq_reg <= freq_calc;
            on_reg   <= on_calc;
            off_reg  <= off_calc;
        end
    end

    assign event_ch.valid      = valid_reg;
    assign event_ch.event_kind = kind_reg;
    assign event_ch.freq_hz    = freq_reg;
    assign event_ch.on_ms      = on_reg;
    assign event_ch.off_ms     = off_reg;

endmodule

/* design/note_string_sequencer.sv */
// Top level of the note string sequencer: register block, front end, queue, back end.
`timescale 1ns / 1ps

// Channel   | Role   | Payload                                   | Transfer when
// ----------+--------+-------------------------------------------+--------------------
// char_ch   | sink   | ch[7:0]                                   | valid && ready
// event_ch  | source | event_kind, freq_hz[14:0], on_ms, off_ms  | valid && ready
// APB       | slave  | quarter note length at byte address 0     | psel&penable&pwrite
//
// One character per cycle while the queue has room. The front end updates octave,
// duration and meter skip in the cycle of the transfer; a tone or rest is written
// into the queue at the character's transfer edge and then, once the back end pops
// it, into the back-end output register (where the single divide-by-ten multiply
// sits), from which event_ch offers it.
// Reset puts octave 4, a quarter-note duration of 800 ms and an idle meter skip.
// char_ch.ready drops only when the four-entry queue is full; the output
// register is reloaded in the same cycle its event transfers, so a stalled
// event_ch backs up through the queue before the front end stalls.

module note_string_sequencer
    import nss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    nss_char_if.sink     char_ch,
    nss_event_if.source  event_ch
);

    logic [QUARTER_W-1:0] quarter_len;
    nss_push_t            push;
    logic                 push_ready;
    nss_head_t            head;
    logic                 pop;

    // Quarter note length register; a write takes effect at the next
    // duration letter or end of song.
    nss_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .quarter_len (quarter_len)
    );

    // Classify each character; notes and rests become queued events.
    nss_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .quarter_len (quarter_len),
        .push_ready  (push_ready),
        .push        (push),
        .char_ch     (char_ch)
    );

    // Decouple the front end from output stalls.
    nss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    // Compute frequency and on/off times, hold the event until it transfers.
    nss_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .event_ch (event_ch)
    );

endmodule

/* tb/sv/nss_checker.sv */
// Event checker for the note string sequencer: tracks the song state, predicts events, compares.
`timescale 1ns / 1ps

module nss_checker
    import nss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    nss_char_if         char_ch,
    nss_event_if        event_ch,
    output int          fail_count,
    output int          events_due
);

    // Meter mark skip: waiting for numerator, slash, denominator.
    localparam logic [1:0] METER_IDLE  = 2'd0;
    localparam logic [1:0] METER_NUM   = 2'd1;
    localparam logic [1:0] METER_SLASH = 2'd2;
    localparam logic [1:0] METER_DEN   = 2'd3;

    localparam logic [2:0]        QUARTER_ADDR = {REG_QUARTER, 2'b00};
    localparam logic [OCT_W-1:0]  OCT_PIVOT    = 4'd4;
    localparam longint unsigned   DUR_TOP      = (64'd1 << DUR_BITS) - 64'd1;
    localparam longint unsigned   OUT_TOP      = 64'd65535;

    typedef struct packed {
        logic              kind;
        logic [FREQ_W-1:0] freq_hz;
        logic [OUT_W-1:0]  on_ms;
        logic [OUT_W-1:0]  off_ms;
    } note_event_t;

    logic [QUARTER_W-1:0] quarter_len;
    logic [OCT_W-1:0]     octave;
    dur_t                 duration;
    logic [1:0]           meter_phase;
    note_event_t          song_events[$];
    note_event_t          want;
    note_event_t          made;
    int                   fails;

    function automatic dur_t clamp_dur(input longint unsigned v);
        return (v > DUR_TOP) ? dur_t'(DUR_TOP) : dur_t'(v);
    endfunction

    function automatic logic [OUT_W-1:0] clamp_out(input longint unsigned v);
        return (v > OUT_TOP) ? 16'hFFFF : v[OUT_W-1:0];
    endfunction

    // Advance the song state by one character; return 1 when it sounds a tone or a rest.
    function automatic bit play_char(input logic [7:0] c, output note_event_t ev);
        longint unsigned q;
        longint unsigned d;
        longint unsigned f;
        longint unsigned on_t;
        logic [7:0]      tone_idx;
        bit              is_digit;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        q = quarter_len;
        d = duration;
        ev = '0;
        if (c == CH_NUL) begin
            octave = OCT_RST;
            duration = clamp_dur(q);
            meter_phase = METER_IDLE;
            return 1'b0;
        end
        // Each part of a meter mark is swallowed only when it matches; a mismatch falls through.
        if (meter_phase == METER_NUM) begin
            meter_phase = METER_SLASH;
            if (is_digit)
                return 1'b0;
        end
        if (meter_phase == METER_SLASH) begin
            meter_phase = METER_DEN;
            if (c == CH_SLASH)
                return 1'b0;
        end
        if (meter_phase == METER_DEN) begin
            meter_phase = METER_IDLE;
            if (is_digit)
                return 1'b0;
        end
        if (is_digit) begin
            octave = OCT_W'(c - CH_ZERO);
            return 1'b0;
        end
        case (c)
            CH_M:
            begin
                meter_phase = METER_NUM;
                return 1'b0;
            end
            CH_W:
            begin
                duration = clamp_dur(q * 4);
                return 1'b0;
            end
            CH_H:
            begin
                duration = clamp_dur(q * 2);
                return 1'b0;
            end
            CH_Q:
            begin
                duration = clamp_dur(q);
                return 1'b0;
            end
            CH_E:
            begin
                duration = clamp_dur(q / 2);
                return 1'b0;
            end
            CH_S:
            begin
                duration = clamp_dur(q / 4);
                return 1'b0;
            end
            CH_T:
            begin
                duration = dur_t'((d * 2) / 3);
                return 1'b0;
            end
            CH_DOT:
            begin
                duration = clamp_dur((d * 3) / 2);
                return 1'b0;
            end
            default: ;
        endcase
        if (c == CH_R) begin
            ev.kind = EVT_REST;
            ev.off_ms = clamp_out(d);
            return 1'b1;
        end
        if ((c >= CH_A) && (c <= CH_G)) begin
            tone_idx = c - CH_A;
            case (tone_idx)
                8'd0:    f = 440;
                8'd1:    f = 494;
                8'd2:    f = 523;
                8'd3:    f = 587;
                8'd4:    f = 659;
                8'd5:    f = 698;
                default: f = 784;
            endcase
            if (octave >= OCT_PIVOT)
                f = f << (octave - OCT_PIVOT);
            else
                f = f >> (OCT_PIVOT - octave);
            on_t = (d * 9) / 10;
            ev.kind = EVT_TONE;
            ev.freq_hz = f[FREQ_W-1:0];
            ev.on_ms = clamp_out(on_t);
            ev.off_ms = clamp_out(d - on_t);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            quarter_len = QUARTER_RST;
            octave = OCT_RST;
            duration = dur_t'(QUARTER_RST);
            meter_phase = METER_IDLE;
            song_events.delete();
            fails = 0;
        end else begin
            if (event_ch.valid && event_ch.ready) begin
                if (song_events.size() == 0) begin
                    $error("event with none due: kind %0d freq_hz %0d on_ms %0d off_ms %0d",
                           event_ch.event_kind, event_ch.freq_hz, event_ch.on_ms,
                           event_ch.off_ms);
                    fails++;
                end else begin
                    want = song_events.pop_front();
                    if (event_ch.event_kind !== want.kind) begin
                        $error("event_kind: expected %0d, actual %0d",
                               want.kind, event_ch.event_kind);
                        fails++;
                    end
                    if (event_ch.freq_hz !== want.freq_hz) begin
                        $error("freq_hz: expected %0d, actual %0d",
                               want.freq_hz, event_ch.freq_hz);
                        fails++;
                    end
                    if (event_ch.on_ms !== want.on_ms) begin
                        $error("on_ms: expected %0d, actual %0d", want.on_ms, event_ch.on_ms);
                        fails++;
                    end
                    if (event_ch.off_ms !== want.off_ms) begin
                        $error("off_ms: expected %0d, actual %0d", want.off_ms, event_ch.off_ms);
                        fails++;
                    end
                end
            end
            if (psel && penable && pwrite && pready && (paddr == QUARTER_ADDR))
                quarter_len = pwdata[QUARTER_W-1:0];
            if (char_ch.valid && char_ch.ready) begin
                if (play_char(char_ch.ch, made))
                    song_events.push_back(made);
            end
        end
        fail_count <= fails;
        events_due <= song_events.size();
    end

endmodule

/* tb/sv/tb_top.sv */
// Top of the note string sequencer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top
    import nss_pkg::*;
();

    // Cycles with no transfer on either channel before the run is declared hung.
    localparam int QUIET_LIMIT  = 4000;
    // Cycles to let the front end settle once no event is due any more.
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 180;

    localparam logic [2:0] QUARTER_ADDR = {REG_QUARTER, 2'b00};

    // Opening sequence: extremes, every note letter but F and every duration code, meter marks
    // whole, broken and cut by NUL, and characters that must be ignored.
    localparam logic [7:0] OPENING [28] = '{
        8'hFF,                 // all ones, ignored
        CH_NUL,                // end of song on an already idle block
        CH_A,                  // tone at reset octave and duration
        CH_R,                  // rest of reset duration
        CH_ZERO + 8'd9,        // highest octave
        CH_G,                  // highest frequency
        CH_ZERO,               // lowest octave
        CH_A,                  // lowest frequency
        CH_W,
        CH_DOT,
        CH_A + 8'd1,
        CH_S,
        CH_T,
        CH_A + 8'd4,
        CH_M,                  // well formed meter mark, fully swallowed
        CH_ZERO + 8'd3,
        CH_SLASH,
        CH_ZERO + 8'd4,
        CH_A + 8'd2,
        CH_M,                  // meter mark broken at once
        8'h28,
        CH_M,                  // NUL in the middle of a meter mark
        CH_NUL,
        CH_H,
        CH_E,
        8'h7A,                 // lowercase letter with no meaning
        CH_Q,
        CH_A + 8'd3
    };

    localparam logic [7:0] DUR_LETTERS [5] = '{CH_W, CH_H, CH_Q, CH_E, CH_S};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    nss_char_if  char_ch ();
    nss_event_if event_ch ();

    int          fail_count;
    int          events_due;
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    int          quiet_cycles;
    int          phase_items;
    logic [QUARTER_W-1:0] quarter_plan [PHASES] = '{
        12'd800, 12'd200, 12'd4000, 12'd4095, 12'd0, 12'd1, 12'd2000, 12'd4000
    };

    note_string_sequencer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .char_ch  (char_ch),
        .event_ch (event_ch)
    );

    nss_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .char_ch    (char_ch),
        .event_ch   (event_ch),
        .fail_count (fail_count),
        .events_due (events_due)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: drop ready at random, as often as the current phase asks.
    always @(posedge clk)
    begin
        event_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog: count cycles without a transfer on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (char_ch.valid && char_ch.ready) || (event_ch.valid && event_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one character, with random gaps before it, and hold it until the transfer.
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            char_ch.valid <= 1'b0;
            @(posedge clk);
        end
        char_ch.valid <= 1'b1;
        char_ch.ch <= c;
        do
            @(posedge clk);
        while (!char_ch.ready);
        phase_items++;
    endtask

    // Send one musical phrase: mostly well formed, with some broken marks and noise.
    task automatic play_phrase();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            send_char(CH_A + 8'($urandom_range(0, 6)));
        end
        else if (pick < 33)
        begin
            send_char(CH_R);
        end
        else if (pick < 45)
        begin
            send_char(DUR_LETTERS[$urandom_range(0, 4)]);
        end
        else if (pick < 52)
        begin
            send_char(CH_T);
        end
        else if (pick < 58)
        begin
            // Dot chains long enough to drive the duration into saturation.
            n = $urandom_range(1, 5);
            repeat (n) send_char(CH_DOT);
        end
        else if (pick < 68)
        begin
            send_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        else if (pick < 78)
        begin
            send_char(CH_M);
            send_char(CH_ZERO + 8'($urandom_range(0, 9)));
            send_char(CH_SLASH);
            send_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        else if (pick < 84)
        begin
            // Broken meter mark: each part right or any byte at all.
            send_char(CH_M);
            send_char(($urandom_range(0, 1) != 0) ? CH_ZERO + 8'($urandom_range(0, 9))
                                                  : 8'($urandom_range(0, 255)));
            send_char(($urandom_range(0, 1) != 0) ? CH_SLASH : 8'($urandom_range(0, 255)));
            send_char(($urandom_range(0, 1) != 0) ? CH_ZERO + 8'($urandom_range(0, 9))
                                                  : 8'($urandom_range(0, 255)));
        end
        else if (pick < 87)
        begin
            send_char(CH_NUL);
        end
        else
        begin
            send_char(8'($urandom_range(0, 255)));
        end
    endtask

    // Drop valid and wait until every event has come out and the front end is quiet.
    task automatic wait_idle();
        char_ch.valid <= 1'b0;
        @(posedge clk);
        while (events_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write: setup, then access.
    task automatic write_quarter(input logic [QUARTER_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= QUARTER_ADDR;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        char_ch.valid <= 1'b0;
        char_ch.ch <= CH_NUL;
        quarter_plan[6] = QUARTER_W'($urandom_range(0, 4095));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++)
        begin
            // Idle phases rotate: none, sender gaps, receiver stalls, light on both sides.
            case (p % 4)
                0:
                begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct = 80;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct = 0;
                    stall_pct = 80;
                end
                default:
                begin
                    gap_pct = 6;
                    stall_pct = 6;
                end
            endcase
            wait_idle();
            // Phase zero first plays the opening at the reset quarter length.
            if (p == 0)
            begin
                foreach (OPENING[i])
                    send_char(OPENING[i]);
                wait_idle();
            end
            write_quarter(quarter_plan[p]);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                play_phrase();
        end

        wait_idle();
        if (fail_count == 0 && events_due == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
